[src/qpht_pkg.sv]
// Shared constants, types and control structs for the quadratic probe hash table.
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

    // Table geometry and key width
    localparam int TABLE_DEPTH = 16384;
    localparam int KEY_BITS    = 20;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int ENTRY_W     = KEY_BITS + 1;

    // Remainder unit: two key bits per step, key padded to an even width
    localparam int KEY_PAD     = KEY_BITS + (KEY_BITS % 2);
    localparam int DIV_STEPS   = KEY_PAD / 2;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // Configuration port
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;
    localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = PADDR_W'(0);
    localparam logic [SIZE_W-1:0]  SIZE_RESET      = SIZE_W'(TABLE_DEPTH);

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PROBE,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_write;
        logic load;
        logic div_step;
        logic advance;
        logic capture;
        logic mem_write;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic is_insert;
        logic found;
        logic stop;
    } status_t;

endpackage

`default_nettype wire

[src/qpht_ifs.sv]
// Valid/ready channel interfaces for the request and result items.
`timescale 1ns / 1ps
`default_nettype none

interface qpht_in_if ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [qpht_pkg::KEY_BITS-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface qpht_out_if ();
    logic                        valid;
    logic                        ready;
    logic [qpht_pkg::ADDR_W-1:0] slot;
    logic                        success;
    logic [qpht_pkg::SIZE_W-1:0] probe_count;

    modport source (output valid, output slot, output success, output probe_count,
                    input ready);
    modport sink   (input valid, input slot, input success, input probe_count,
                    output ready);
endinterface

`default_nettype wire

[src/qpht_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[src/qpht_dp.sv]
// Datapath: key remainder unit, probe stepper, slot store and result registers.
`timescale 1ns / 1ps
`default_nettype none

module qpht_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire qpht_pkg::cmd_t                cmd,
    output qpht_pkg::status_t                  status,
    input  wire logic [qpht_pkg::SIZE_W-1:0]   table_size,
    input  wire logic                          in_func,
    input  wire logic [qpht_pkg::KEY_BITS-1:0] in_key,
    output logic      [qpht_pkg::ADDR_W-1:0]   out_slot,
    output logic                               out_success,
    output logic      [qpht_pkg::SIZE_W-1:0]   out_probe_count
);

    localparam int AW = qpht_pkg::ADDR_W;
    localparam int SW = qpht_pkg::SIZE_W;
    localparam int KW = qpht_pkg::KEY_BITS;
    localparam int PW = qpht_pkg::KEY_PAD;

    logic [SW-1:0]  s_reg;
    logic [KW-1:0]  key_reg;
    logic           func_reg;
    logic [PW-1:0]  div_sh_reg;
    logic [AW-1:0]  rem_reg;
    logic [qpht_pkg::STEP_W-1:0] step_reg;
    logic [AW-1:0]  j_reg;
    logic [AW-1:0]  d_reg;
    logic [2:0]     four_reg;
    logic [SW-1:0]  cnt_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic [AW-1:0]  res_slot_reg;
    logic           res_ok_reg;
    logic [SW-1:0]  res_cnt_reg;
    logic [AW-1:0]  out_slot_reg;
    logic           out_ok_reg;
    logic [SW-1:0]  out_cnt_reg;

    logic [SW-1:0]  s_eff;
    logic [AW-1:0]  three_mod;
    logic [2:0]     four_mod;
    logic [SW-1:0]  t1_wide;
    logic [AW-1:0]  t1;
    logic [SW-1:0]  t2_wide;
    logic [AW-1:0]  rem_next;
    logic [SW-1:0]  j_sum;
    logic [AW-1:0]  j_next;
    logic [SW-1:0]  d_sum;
    logic [AW-1:0]  d_next;

    logic                            ram_we;
    logic [AW-1:0]                   ram_addr;
    logic [qpht_pkg::ENTRY_W-1:0]    ram_wdata;
    logic [qpht_pkg::ENTRY_W-1:0]    ram_rdata;
    logic                            slot_used;
    logic                            key_match;

    // Clamp the configured size to 1..TABLE_DEPTH
    always_comb
    begin
        if (table_size == '0)
        begin
            s_eff = SW'(1);
        end
        else if (table_size > SW'(qpht_pkg::TABLE_DEPTH))
        begin
            s_eff = SW'(qpht_pkg::TABLE_DEPTH);
        end
        else
        begin
            s_eff = table_size;
        end
    end

    // First step 3 and step increment 4, both reduced by the table size
    always_comb
    begin
        case (s_eff)
            SW'(1), SW'(3): three_mod = '0;
            SW'(2):         three_mod = AW'(1);
            default:        three_mod = AW'(3);
        endcase
        case (s_eff)
            SW'(1), SW'(2), SW'(4): four_mod = 3'd0;
            SW'(3):                 four_mod = 3'd1;
            default:                four_mod = 3'd4;
        endcase
    end

    // Remainder step: shift in two key bits, conditional subtract after each
    always_comb
    begin
        t1_wide = {rem_reg, div_sh_reg[PW-1]};
        if (t1_wide >= s_reg)
        begin
            t1_wide = t1_wide - s_reg;
        end
        t1 = t1_wide[AW-1:0];
        t2_wide = {t1, div_sh_reg[PW-2]};
        if (t2_wide >= s_reg)
        begin
            t2_wide = t2_wide - s_reg;
        end
        rem_next = t2_wide[AW-1:0];
    end

    // Next probe slot: j += d, d += 4, both kept below the table size
    always_comb
    begin
        j_sum = {1'b0, j_reg} + {1'b0, d_reg};
        if (j_sum >= s_reg)
        begin
            j_sum = j_sum - s_reg;
        end
        j_next = j_sum[AW-1:0];
        d_sum = {1'b0, d_reg} + SW'(four_reg);
        if (d_sum >= s_reg)
        begin
            d_sum = d_sum - s_reg;
        end
        d_next = d_sum[AW-1:0];
    end

    // Operation registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg      <= s_eff;
            key_reg    <= in_key;
            func_reg   <= in_func;
            div_sh_reg <= PW'(in_key);
            rem_reg    <= '0;
            d_reg      <= three_mod;
            four_reg   <= four_mod;
            cnt_reg    <= SW'(1);
        end
        else if (cmd.div_step)
        begin
            div_sh_reg <= {div_sh_reg[PW-3:0], 2'b00};
            rem_reg    <= rem_next;
            j_reg      <= rem_next;
        end
        else if (cmd.advance)
        begin
            j_reg   <= j_next;
            d_reg   <= d_next;
            cnt_reg <= cnt_reg + SW'(1);
        end
    end

    // Step counter of the remainder unit and the clearing address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + qpht_pkg::STEP_W'(1);
            end
            if (cmd.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Slot store: occupied flag on top of the key
    assign ram_we    = cmd.clr_write | cmd.mem_write;
    assign ram_addr  = cmd.clr_write ? clr_addr_reg : j_reg;
    assign ram_wdata = cmd.clr_write ? '0 : {1'b1, key_reg};

    qpht_ram #(
        .WIDTH (qpht_pkg::ENTRY_W),
        .DEPTH (qpht_pkg::TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Probe decision
    assign slot_used = ram_rdata[KW];
    assign key_match = slot_used && (ram_rdata[KW-1:0] == key_reg);

    always_comb
    begin
        status           = '0;
        status.clr_last  = (clr_addr_reg == AW'(qpht_pkg::TABLE_DEPTH - 1));
        status.div_last  = (step_reg == qpht_pkg::STEP_W'(qpht_pkg::DIV_STEPS - 1));
        status.is_insert = (func_reg == qpht_pkg::FUNC_INSERT);
        status.found     = status.is_insert ? !slot_used : key_match;
        status.stop      = status.found || !slot_used || (cnt_reg == s_reg);
    end

    // Finished result, then output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_ok_reg   <= status.found;
            res_slot_reg <= status.found ? j_reg : '0;
            res_cnt_reg  <= cnt_reg;
        end
        if (cmd.out_load)
        begin
            out_ok_reg   <= res_ok_reg;
            out_slot_reg <= res_slot_reg;
            out_cnt_reg  <= res_cnt_reg;
        end
    end

    assign out_slot        = out_slot_reg;
    assign out_success     = out_ok_reg;
    assign out_probe_count = out_cnt_reg;

endmodule

`default_nettype wire

[src/qpht_ctrl.sv]
// Controller: clearing pass, remainder steps, probe loop and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module qpht_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire qpht_pkg::status_t    status,
    output qpht_pkg::cmd_t            cmd
);

    qpht_pkg::state_t state_reg;
    qpht_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qpht_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            qpht_pkg::ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                begin
                    state_next = qpht_pkg::ST_IDLE;
                end
            end
            qpht_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = qpht_pkg::ST_DIV;
                end
            end
            qpht_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = qpht_pkg::ST_PROBE;
                end
            end
            qpht_pkg::ST_PROBE:
            begin
                // store read of the current slot is under way
                state_next = qpht_pkg::ST_CHECK;
            end
            qpht_pkg::ST_CHECK:
            begin
                if (status.stop)
                begin
                    cmd.capture   = 1'b1;
                    cmd.mem_write = status.found && status.is_insert;
                    state_next    = qpht_pkg::ST_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = qpht_pkg::ST_PROBE;
                end
            end
            qpht_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = qpht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qpht_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register is full until the item is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[src/quadratic_probe_hash_table_unit.sv]
// Top level: quadratic probing hash table with request, result and APB config ports.
//
//   Channel   Dir  Handshake      Item contents
//   in_ch     in   valid/ready    func (0 insert, 1 search), key
//   out_ch    out  valid/ready    slot, success, probe_count
//   APB       in   psel/penable   table_size at byte address 0
//
// An item goes through an accept state, ten remainder steps (two key bits each)
// to get key mod table_size, then one store read and one check per probe on the
// single store port, and a hand-off state.
// After reset a clearing pass writes all 16384 slots, one a cycle; no item is
// accepted during the pass. The next item is taken while a result still waits
// in the output register; a stalled output holds the block in its hand-off state.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    qpht_in_if.sink                            in_ch,
    qpht_out_if.source                         out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [qpht_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [qpht_pkg::PDATA_W-1:0]  pwdata,
    output logic      [qpht_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    logic [qpht_pkg::SIZE_W-1:0] table_size_reg;
    qpht_pkg::cmd_t              cmd;
    qpht_pkg::status_t           status;
    logic                        cfg_write;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == qpht_pkg::ADDR_TABLE_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= qpht_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            table_size_reg <= pwdata[qpht_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = (paddr == qpht_pkg::ADDR_TABLE_SIZE) ?
                    qpht_pkg::PDATA_W'(table_size_reg) : '0;

    qpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    qpht_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .table_size      (table_size_reg),
        .in_func         (in_ch.func),
        .in_key          (in_ch.key),
        .out_slot        (out_ch.slot),
        .out_success     (out_ch.success),
        .out_probe_count (out_ch.probe_count)
    );

endmodule

`default_nettype wire

[src/qpht_checker.sv]
// Port-level assertions for the hash table unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module qpht_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [qpht_pkg::ADDR_W-1:0] slot,
    input  wire logic                        success,
    input  wire logic [qpht_pkg::SIZE_W-1:0] probe_count
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // One item in work at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in work");

    // An unsuccessful operation reports slot zero
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !success |-> slot == '0)
        else $error("failed operation with nonzero slot");

    // Probe count stays within 1..TABLE_DEPTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (probe_count != '0) &&
                      (probe_count <= qpht_pkg::SIZE_W'(qpht_pkg::TABLE_DEPTH)))
        else $error("probe count out of range");

endmodule

bind quadratic_probe_hash_table_unit qpht_checker u_qpht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .slot        (out_ch.slot),
    .success     (out_ch.success),
    .probe_count (out_ch.probe_count)
);

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the quadratic probe hash table unit.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [qpht_pkg::ADDR_W-1:0] slot;
        logic                        success;
        logic [qpht_pkg::SIZE_W-1:0] probes;
    } probe_outcome_t;

    // Clock, reset and config port
    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [qpht_pkg::PADDR_W-1:0] paddr;
    logic [qpht_pkg::PDATA_W-1:0] pwdata;
    logic [qpht_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    qpht_in_if  in_ch ();
    qpht_out_if out_ch ();

    quadratic_probe_hash_table_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Shadow copy of the table and its size register
    bit                            slot_taken [qpht_pkg::TABLE_DEPTH];
    logic [qpht_pkg::KEY_BITS-1:0] slot_key   [qpht_pkg::TABLE_DEPTH];
    logic [qpht_pkg::SIZE_W-1:0]   size_reg = qpht_pkg::SIZE_RESET;

    probe_outcome_t                pending_outcomes [$];
    logic [qpht_pkg::KEY_BITS-1:0] inserted_keys [$];
    int                            fail_cnt  = 0;
    int                            gap_next  = 0;
    int                            stall_left = 0;
    bit                            quiet     = 1'b0;

    function automatic int unsigned span_of(logic [qpht_pkg::SIZE_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > qpht_pkg::TABLE_DEPTH)
            return qpht_pkg::TABLE_DEPTH;
        return r;
    endfunction

    // Walk the probe path, update the shadow table, return the outcome
    function automatic probe_outcome_t probe_table(logic op,
                                                   logic [qpht_pkg::KEY_BITS-1:0] k);
        int unsigned     span;
        longint unsigned pos;
        probe_outcome_t  res;
        span = span_of(size_reg);
        for (longint unsigned p = 0; p < span; p++)
        begin
            pos = (longint'(k) + p + 2 * p * p) % span;
            if (op == qpht_pkg::FUNC_INSERT)
            begin
                if (!slot_taken[pos])
                begin
                    slot_taken[pos] = 1'b1;
                    slot_key[pos]   = k;
                    res.slot        = qpht_pkg::ADDR_W'(pos);
                    res.success     = 1'b1;
                    res.probes      = qpht_pkg::SIZE_W'(p + 1);
                    return res;
                end
            end
            else
            begin
                if (!slot_taken[pos] || slot_key[pos] == k)
                begin
                    res.slot    = slot_taken[pos] ? qpht_pkg::ADDR_W'(pos) : '0;
                    res.success = slot_taken[pos];
                    res.probes  = qpht_pkg::SIZE_W'(p + 1);
                    return res;
                end
            end
        end
        // Path exhausted: table full or key absent
        res.slot    = '0;
        res.success = 1'b0;
        res.probes  = qpht_pkg::SIZE_W'(span);
        return res;
    endfunction

    function automatic void report_bad(string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%s", msg);
    endfunction

    // Mostly short gaps, a few long ones, none in quiet phases
    function automatic int draw_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Send one item and record its expected outcome on acceptance
    task automatic send_item(logic op, logic [qpht_pkg::KEY_BITS-1:0] k);
        repeat (gap_next) @(posedge clk);
        in_ch.valid <= 1'b1;
        in_ch.func  <= op;
        in_ch.key   <= k;
        do @(posedge clk); while (!in_ch.ready);
        pending_outcomes.push_back(probe_table(op, k));
        gap_next = draw_gap();
        if (gap_next > 0)
            in_ch.valid <= 1'b0;
    endtask

    // Stop sending and wait for every expected item to come back
    task automatic drain();
        if (gap_next == 0)
            in_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // APB write of table_size, then read it back
    task automatic write_table_size(logic [qpht_pkg::PDATA_W-1:0] value);
        logic [qpht_pkg::PDATA_W-1:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= qpht_pkg::ADDR_TABLE_SIZE;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        size_reg = value[qpht_pkg::SIZE_W-1:0];
        // read-back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        want = qpht_pkg::PDATA_W'(size_reg);
        if (prdata !== want)
            report_bad($sformatf("table_size read: expected %0d, got %0d", want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        probe_outcome_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_bad($sformatf("unexpected item: slot %0d success %0b probes %0d",
                                     out_ch.slot, out_ch.success, out_ch.probe_count));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (out_ch.slot !== want.slot || out_ch.success !== want.success ||
                    out_ch.probe_count !== want.probes)
                    report_bad($sformatf(
                        "mismatch: expected slot %0d success %0b probes %0d, got %0d %0b %0d",
                        want.slot, want.success, want.probes,
                        out_ch.slot, out_ch.success, out_ch.probe_count));
            end
        end
    end

    // Result-side back-pressure
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    // Default size: extreme keys, key zero, collisions and duplicates
    task automatic test_basic_ops();
        send_item(qpht_pkg::FUNC_INSERT, 20'hFFFFF);
        send_item(qpht_pkg::FUNC_SEARCH, 20'hFFFFF);
        send_item(qpht_pkg::FUNC_SEARCH, 20'h00000);
        send_item(qpht_pkg::FUNC_INSERT, 20'h00000);
        send_item(qpht_pkg::FUNC_SEARCH, 20'h00000);
        send_item(qpht_pkg::FUNC_INSERT, 20'd16384);
        send_item(qpht_pkg::FUNC_INSERT, 20'h00000);
        send_item(qpht_pkg::FUNC_SEARCH, 20'd16384);
        drain();
    endtask

    // Size zero acts as one slot: full insert and exhausted search
    task automatic test_single_slot();
        write_table_size(32'd0);
        send_item(qpht_pkg::FUNC_INSERT, 20'd5);
        send_item(qpht_pkg::FUNC_SEARCH, 20'h00000);
        send_item(qpht_pkg::FUNC_SEARCH, 20'd7);
        drain();
    endtask

    // Size above the depth clamps to the depth; stored keys kept
    task automatic test_size_clamp();
        write_table_size(32'h7FFF);
        send_item(qpht_pkg::FUNC_SEARCH, 20'hFFFFF);
        send_item(qpht_pkg::FUNC_INSERT, 20'd1);
        send_item(qpht_pkg::FUNC_SEARCH, 20'd1);
        drain();
        write_table_size(32'(qpht_pkg::TABLE_DEPTH));
        send_item(qpht_pkg::FUNC_SEARCH, 20'd16384);
        drain();
    endtask

    // Tiny table where the probe path misses a free slot
    task automatic test_tiny_wrap();
        write_table_size(32'd3);
        send_item(qpht_pkg::FUNC_INSERT, 20'd3);
        send_item(qpht_pkg::FUNC_INSERT, 20'd2);
        send_item(qpht_pkg::FUNC_INSERT, 20'd4);
        send_item(qpht_pkg::FUNC_SEARCH, 20'd5);
        send_item(qpht_pkg::FUNC_SEARCH, 20'd2);
        send_item(qpht_pkg::FUNC_SEARCH, 20'd1);
        drain();
    endtask

    // One random phase at a given size
    task automatic test_random_phase(logic [qpht_pkg::PDATA_W-1:0] size_val, int n_items,
                                     bit no_gaps);
        int unsigned                   span;
        int                            r;
        logic [qpht_pkg::KEY_BITS-1:0] k;
        write_table_size(size_val);
        quiet = no_gaps;
        span  = span_of(size_val[qpht_pkg::SIZE_W-1:0]);
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45 || inserted_keys.size() == 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    k = qpht_pkg::KEY_BITS'($urandom_range(0, 4 * span + 3));
                else if (r < 9 || inserted_keys.size() == 0)
                    k = qpht_pkg::KEY_BITS'($urandom_range(0, 20'hFFFFF));
                else
                    k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                inserted_keys.push_back(k);
                if (inserted_keys.size() > 256)
                    void'(inserted_keys.pop_front());
                send_item(qpht_pkg::FUNC_INSERT, k);
            end
            else if (r < 85)
            begin
                k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                send_item(qpht_pkg::FUNC_SEARCH, k);
            end
            else
            begin
                send_item(qpht_pkg::FUNC_SEARCH,
                          qpht_pkg::KEY_BITS'($urandom_range(0, 20'hFFFFF)));
            end
        end
        drain();
        quiet = 1'b0;
    endtask

    initial
    begin
        logic [qpht_pkg::PDATA_W-1:0] sizes [14] = '{2, 5, 16, 37, 0, 64, 128, 255,
                                                     16384, 1000, 32767, 256, 7, 1};
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= qpht_pkg::FUNC_INSERT;
        in_ch.key    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_single_slot();
        test_size_clamp();
        test_tiny_wrap();
        foreach (sizes[i])
            test_random_phase(sizes[i], 82, (i % 4) == 3);

        repeat (1000) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
